@@ rtl/qtd_pkg.sv @@
// Shared types and constants for the quadtree bitmap decoder.
// Symbol codes, the item kinds passed from the front end to the back end, and the result record.
// No dependencies.
package qtd_pkg;

  localparam int SYM_W  = 8;
  localparam int SIZE_W = 4;
  localparam int ROW_W  = 10;
  localparam int SIDE_W = 4;

  localparam logic [SYM_W-1:0] SYM_WHITE = 8'd48;
  localparam logic [SYM_W-1:0] SYM_BLACK = 8'd49;
  localparam logic [SYM_W-1:0] SYM_SPLIT = 8'd52;

  localparam logic [SIZE_W-1:0] SIZE_LOG_RST = 4'd4;

  typedef logic [1:0] kind_t;

  localparam kind_t KIND_WHITE = 2'd0;
  localparam kind_t KIND_BLACK = 2'd1;
  localparam kind_t KIND_SPLIT = 2'd2;
  localparam kind_t KIND_BAD   = 2'd3;

  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [ROW_W-1:0]  col;
    logic [SIDE_W-1:0] side_log;
    logic              colour;
    logic              tree_done;
    logic              error;
  } res_t;

endpackage

@@ rtl/quadtree_bitmap_decoder_top.sv @@
// A symbol transfer queues its kind; the back end pops it and registers the leaf or error
// result on out_*. The stack update and priority pop are combinational, ahead of that register.
// Throughput: one symbol per cycle unless the output stalls.
// A two-entry queue separates symbol classification from the stack walk; output is registered.
// Reset (rst_n, synchronous, active low) sets size_log to 4, empties stack and queue.
// A write on cfg_we loads size_log and restarts decoding.
module quadtree_bitmap_decoder_top #(
  parameter int MAX_LOG = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,    // [3:0] size_log
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,     // [7:0] symbol
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,    // [9:0] row, [19:10] col, [23:20] side_log, [24] colour
  output logic        out_tlast,    // tree_done
  output logic        out_tuser     // error
);

  logic           head_valid;
  qtd_pkg::kind_t head_kind;
  logic           pop;
  qtd_pkg::res_t  res;

  qtd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .head_valid (head_valid),
    .head_kind  (head_kind),
    .pop        (pop)
  );

  qtd_back #(
    .MAX_LOG (MAX_LOG)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .head_valid (head_valid),
    .head_kind  (head_kind),
    .pop        (pop),
    .res_valid  (out_tvalid),
    .res        (res),
    .res_ready  (out_tready)
  );

  assign out_tdata = {7'd0, res.colour, res.side_log, res.col, res.row};
  assign out_tlast = res.tree_done;
  assign out_tuser = res.error;

endmodule

@@ rtl/qtd_front.sv @@
// Front end: takes input symbols, classifies them and queues the kind in a two-entry FIFO.
// Depends on qtd_pkg.
module qtd_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [qtd_pkg::SYM_W-1:0] in_tdata,   // [7:0] symbol
  output logic                      head_valid,
  output qtd_pkg::kind_t            head_kind,
  input  logic                      pop
);

  qtd_pkg::kind_t q_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     count_r, count_nxt;
  qtd_pkg::kind_t kind;
  logic           push;

  always_comb begin
    unique case (in_tdata)
      qtd_pkg::SYM_WHITE: kind = qtd_pkg::KIND_WHITE;
      qtd_pkg::SYM_BLACK: kind = qtd_pkg::KIND_BLACK;
      qtd_pkg::SYM_SPLIT: kind = qtd_pkg::KIND_SPLIT;
      default:            kind = qtd_pkg::KIND_BAD;
    endcase
  end

  assign in_tready  = (count_r != 2'd2);
  assign push       = in_tvalid && in_tready;
  assign head_valid = (count_r != 2'd0);
  assign head_kind  = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= kind;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

@@ rtl/qtd_back.sv @@
// Back end: walks the quadtree on a child-index stack; registers one result per leaf or error.
// Depends on qtd_pkg.
module qtd_back #(
  parameter int MAX_LOG = 10
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [qtd_pkg::SIZE_W-1:0] cfg_wdata,
  input  logic                       head_valid,
  input  qtd_pkg::kind_t             head_kind,
  output logic                       pop,
  output logic                       res_valid,
  output qtd_pkg::res_t              res,
  input  logic                       res_ready
);

  localparam int KW = $clog2(MAX_LOG + 1);
  localparam int IW = (MAX_LOG > 1) ? $clog2(MAX_LOG) : 1;
  localparam int CW = (KW > qtd_pkg::SIZE_W) ? KW : qtd_pkg::SIZE_W;
  localparam int RW = (MAX_LOG > qtd_pkg::ROW_W) ? MAX_LOG : qtd_pkg::ROW_W;

  logic [1:0]                  stack_r [MAX_LOG];
  logic [1:0]                  stack_nxt [MAX_LOG];
  logic [KW-1:0]               depth_r, depth_nxt;
  logic                        fin_r, fin_nxt;
  logic [qtd_pkg::SIZE_W-1:0]  size_log_r, size_log_nxt;
  logic                        out_valid_r, out_valid_nxt;
  qtd_pkg::res_t               out_res_r, out_res_nxt;

  logic [CW-1:0]               size_ext;
  logic [KW-1:0]               k;
  logic [KW-1:0]               side;
  logic [RW-1:0]               r_full, c_full;
  logic                        found;
  logic [KW-1:0]               jsel;
  logic                        produce;
  qtd_pkg::res_t               leaf;

  assign size_ext = CW'(size_log_r);
  assign k        = (size_ext > CW'(MAX_LOG)) ? KW'(MAX_LOG) : KW'(size_ext);
  assign side     = k - depth_r;
  assign pop      = head_valid && (!out_valid_r || res_ready);

  // Position of the current square from the open levels.
  always_comb begin
    r_full = '0;
    c_full = '0;
    for (int i = 0; i < MAX_LOG; i++) begin
      if (KW'(i) < depth_r) begin
        r_full = r_full | (RW'(stack_r[i][0]) << (k - KW'(i) - KW'(1)));
        c_full = c_full | (RW'(stack_r[i][1]) << (k - KW'(i) - KW'(1)));
      end
    end
  end

  // Deepest open level with a sibling left to visit.
  always_comb begin
    found = 1'b0;
    jsel  = '0;
    for (int i = 0; i < MAX_LOG; i++) begin
      if (KW'(i) < depth_r && stack_r[i] != 2'd3) begin
        found = 1'b1;
        jsel  = KW'(i);
      end
    end
  end

  always_comb begin
    leaf           = '0;
    leaf.row       = r_full[qtd_pkg::ROW_W-1:0];
    leaf.col       = c_full[qtd_pkg::ROW_W-1:0];
    leaf.side_log  = qtd_pkg::SIDE_W'(side);
    leaf.colour    = (head_kind == qtd_pkg::KIND_BLACK);
    leaf.tree_done = !found;
  end

  always_comb begin
    stack_nxt    = stack_r;
    depth_nxt    = depth_r;
    fin_nxt      = fin_r;
    size_log_nxt = size_log_r;
    produce      = 1'b0;
    out_res_nxt  = out_res_r;
    if (cfg_we) begin
      size_log_nxt = cfg_wdata;
      depth_nxt    = '0;
      fin_nxt      = 1'b0;
      for (int i = 0; i < MAX_LOG; i++) begin
        stack_nxt[i] = 2'd0;
      end
    end else if (pop) begin
      if (fin_r) begin
        produce           = 1'b1;
        out_res_nxt       = '0;
        out_res_nxt.error = 1'b1;
      end else begin
        unique case (head_kind) inside
          qtd_pkg::KIND_SPLIT: begin
            if (side == '0) begin
              produce           = 1'b1;
              out_res_nxt       = '0;
              out_res_nxt.error = 1'b1;
            end else begin
              stack_nxt[depth_r[IW-1:0]] = 2'd0;
              depth_nxt = depth_r + KW'(1);
            end
          end
          qtd_pkg::KIND_WHITE, qtd_pkg::KIND_BLACK: begin
            produce     = 1'b1;
            out_res_nxt = leaf;
            if (found) begin
              // advance to the next sibling, dropping the exhausted levels
              stack_nxt[jsel[IW-1:0]] = stack_r[jsel[IW-1:0]] + 2'd1;
              depth_nxt = jsel + KW'(1);
            end else begin
              depth_nxt = '0;
              fin_nxt   = 1'b1;
            end
          end
          default: begin
            produce           = 1'b1;
            out_res_nxt       = '0;
            out_res_nxt.error = 1'b1;
          end
        endcase
      end
    end
    out_valid_nxt = out_valid_r && !res_ready;
    if (produce) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r     <= '0;
      fin_r       <= 1'b0;
      size_log_r  <= qtd_pkg::SIZE_LOG_RST;
      out_valid_r <= 1'b0;
      for (int i = 0; i < MAX_LOG; i++) begin
        stack_r[i] <= 2'd0;
      end
    end else begin
      depth_r     <= depth_nxt;
      fin_r       <= fin_nxt;
      size_log_r  <= size_log_nxt;
      out_valid_r <= out_valid_nxt;
      stack_r     <= stack_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign res_valid = out_valid_r;
  assign res       = out_res_r;

`ifndef NO_ASSERTIONS
  a_depth_le_k: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= k) else $error("stack depth exceeds bitmap size");

  a_fin_empty: assert property (@(posedge clk) disable iff (!rst_n)
    fin_r |-> depth_r == '0) else $error("finished tree with open levels");

  a_push_depth: assert property (@(posedge clk) disable iff (!rst_n)
    pop && !cfg_we && !fin_r && head_kind == qtd_pkg::KIND_SPLIT && side != '0
    |=> depth_r == $past(depth_r) + KW'(1)) else $error("split did not push a level");

  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.error |-> out_res_r.row == '0 && out_res_r.col == '0
    && out_res_r.tree_done == 1'b0) else $error("error result carries leaf fields");
`endif

endmodule

@@ tb/qtd_leaf_checker.sv @@
// Checker for the quadtree bitmap decoder: tracks size_log writes, predicts the leaf or error
// result of every accepted symbol that yields one and compares each result transfer against it.
// Depends on qtd_pkg for the symbol codes and the result record.
`timescale 1ns / 1ps

module qtd_leaf_checker #(
  parameter int MAX_LOG = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  input  logic        out_tlast,
  input  logic        out_tuser,
  output int          fail_count,
  output int          pending,
  output int          leaf_count,
  output int          error_count
);

  // decoder state as the block should hold it
  logic [1:0]                 quad_stack [MAX_LOG];
  int                         open_levels;
  bit                         tree_closed;
  logic [qtd_pkg::SIZE_W-1:0] size_reg;

  qtd_pkg::res_t leaf_q [$];

  task automatic restart_tree();
    for (int i = 0; i < MAX_LOG; i++) quad_stack[i] = 2'd0;
    open_levels = 0;
    tree_closed = 1'b0;
  endtask

  task automatic note_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $time);
    fail_count++;
  endtask

  // Returns 1 when the symbol yields a result; updates the tree state.
  function automatic bit decode_symbol(input logic [7:0] sym, output qtd_pkg::res_t r);
    int  k;
    int  d;
    int  side;
    int  sh;
    bit  walking;
    r = '0;
    k = (size_reg > MAX_LOG) ? MAX_LOG : int'(size_reg);
    d = open_levels;
    if (d > k) begin
      d = k;
      open_levels = k;
    end
    side = k - d;
    if (tree_closed || (sym != qtd_pkg::SYM_WHITE && sym != qtd_pkg::SYM_BLACK &&
                        sym != qtd_pkg::SYM_SPLIT)) begin
      r.error = 1'b1;
      return 1'b1;
    end
    if (sym == qtd_pkg::SYM_SPLIT) begin
      if (side == 0) begin
        r.error = 1'b1;
        return 1'b1;
      end
      if (d < MAX_LOG) begin
        quad_stack[d] = 2'd0;
        open_levels = d + 1;
      end
      return 1'b0;
    end
    // child bit 0 moves down a half, bit 1 moves right a half
    for (int i = 0; i < d && i < MAX_LOG; i++) begin
      sh = k - 1 - i;
      r.row[sh] = quad_stack[i][0];
      r.col[sh] = quad_stack[i][1];
    end
    // advance to the next sibling, popping finished levels
    walking = 1'b1;
    while (walking) begin
      if (d == 0) begin
        tree_closed = 1'b1;
        walking = 1'b0;
      end else if (quad_stack[d-1] < 2'd3) begin
        quad_stack[d-1] = quad_stack[d-1] + 2'd1;
        walking = 1'b0;
      end else begin
        d--;
      end
    end
    open_levels = d;
    r.side_log  = side[qtd_pkg::SIDE_W-1:0];
    r.colour    = (sym == qtd_pkg::SYM_BLACK);
    r.tree_done = tree_closed;
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    qtd_pkg::res_t got;
    qtd_pkg::res_t want;
    qtd_pkg::res_t next_res;
    if (!rst_n) begin
      size_reg = qtd_pkg::SIZE_LOG_RST;
      restart_tree();
      leaf_q.delete();
      fail_count  = 0;
      leaf_count  = 0;
      error_count = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.row       = out_tdata[9:0];
        got.col       = out_tdata[19:10];
        got.side_log  = out_tdata[23:20];
        got.colour    = out_tdata[24];
        got.tree_done = out_tlast;
        got.error     = out_tuser;
        if (leaf_q.size() == 0) begin
          note_mismatch("result with nothing pending", longint'(out_tdata), 64'sd0);
        end else begin
          want = leaf_q.pop_front();
          if (got.row !== want.row)
            note_mismatch("row", longint'(got.row), longint'(want.row));
          if (got.col !== want.col)
            note_mismatch("col", longint'(got.col), longint'(want.col));
          if (got.side_log !== want.side_log)
            note_mismatch("side_log", longint'(got.side_log), longint'(want.side_log));
          if (got.colour !== want.colour)
            note_mismatch("colour", longint'(got.colour), longint'(want.colour));
          if (got.tree_done !== want.tree_done)
            note_mismatch("tree_done", longint'(got.tree_done), longint'(want.tree_done));
          if (got.error !== want.error)
            note_mismatch("error", longint'(got.error), longint'(want.error));
          if (want.error) error_count++;
          else leaf_count++;
        end
      end
      if (cfg_we) begin
        size_reg = cfg_wdata;
        restart_tree();
      end
      if (in_tvalid && in_tready) begin
        if (decode_symbol(in_tdata, next_res)) leaf_q.push_back(next_res);
      end
    end
    pending <= leaf_q.size();
  end

endmodule

@@ tb/quadtree_bitmap_decoder_top_test.sv @@
// Testbench top for the quadtree bitmap decoder: drives symbol streams and size_log writes,
// varies source gaps and sink stalls, and reports the verdict from qtd_leaf_checker.
// Depends on qtd_pkg, quadtree_bitmap_decoder_top and qtd_leaf_checker.
`timescale 1ns / 1ps

module quadtree_bitmap_decoder_top_test;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [3:0]  cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic        out_tlast;
  logic        out_tuser;

  int fail_count;
  int pending;
  int leaf_count;
  int error_count;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit hold_req       = 1'b0;
  int sent_total     = 0;
  int size_writes    = 0;
  int split_budget;

  logic [7:0] code_q [$];

  quadtree_bitmap_decoder_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  qtd_leaf_checker leaf_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser),
    .fail_count  (fail_count),
    .pending     (pending),
    .leaf_count  (leaf_count),
    .error_count (error_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // sink side: random stalls, plus a long hold-off on request
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (300) @(posedge clk);
      end else begin
        out_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic send_symbol(input logic [7:0] sym);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= sym;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent_total++;
  endtask

  task automatic send_code();
    while (code_q.size() != 0) send_symbol(code_q.pop_front());
  endtask

  // write size_log only once the decoder has drained
  task automatic write_size(input logic [3:0] value);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    size_writes++;
  endtask

  function automatic logic [7:0] noise_symbol();
    if ($urandom_range(3) == 0) return 8'($urandom_range(53, 46));
    return 8'($urandom_range(255));
  endfunction

  // preorder code of one square at side exponent lvl, with occasional damage
  function automatic void gen_quad(input int lvl);
    if ($urandom_range(99) < 3) code_q.push_back(noise_symbol());
    if (lvl > 0 && code_q.size() < split_budget && $urandom_range(99) < 60) begin
      code_q.push_back(qtd_pkg::SYM_SPLIT);
      for (int j = 0; j < 4; j++) gen_quad(lvl - 1);
    end else begin
      if (lvl == 0 && $urandom_range(99) < 4) code_q.push_back(qtd_pkg::SYM_SPLIT);
      code_q.push_back($urandom_range(1) ? qtd_pkg::SYM_BLACK : qtd_pkg::SYM_WHITE);
    end
  endfunction

  function automatic logic [3:0] pick_size();
    int r;
    r = $urandom_range(99);
    if (r < 8)  return 4'd10;
    if (r < 14) return 4'($urandom_range(15, 11));
    if (r < 22) return 4'd0;
    if (r < 40) return 4'($urandom_range(9, 6));
    return 4'($urandom_range(5, 1));
  endfunction

  initial begin
    logic [3:0] sz;
    int         quota;
    int         cut;
    bit         first_tree;
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_wdata <= 4'd0;
    in_tvalid <= 1'b0;
    in_tdata  <= 8'd0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset size of 4: bad symbols, descend to side one, split there, then fill the tree
    code_q = {8'h00, 8'hFF, 8'h32, qtd_pkg::SYM_SPLIT, qtd_pkg::SYM_SPLIT, qtd_pkg::SYM_SPLIT,
              qtd_pkg::SYM_SPLIT, qtd_pkg::SYM_SPLIT, qtd_pkg::SYM_BLACK, qtd_pkg::SYM_WHITE,
              qtd_pkg::SYM_BLACK, qtd_pkg::SYM_WHITE};
    for (int j = 0; j < 9; j++)
      code_q.push_back(j[0] ? qtd_pkg::SYM_WHITE : qtd_pkg::SYM_BLACK);
    code_q.push_back(qtd_pkg::SYM_BLACK);
    send_code();
    // single-pixel bitmap: no split allowed, one leaf closes the tree
    write_size(4'd0);
    code_q = {qtd_pkg::SYM_SPLIT, qtd_pkg::SYM_WHITE};
    send_code();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
        default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase
      quota = sent_total + 440;
      first_tree = (ph == 0);
      while (sent_total < quota) begin
        sz = first_tree ? 4'd10 : pick_size();
        write_size(sz);
        split_budget = first_tree ? 60 : int'($urandom_range(50, 6));
        gen_quad((sz > 10) ? 10 : int'(sz));
        // truncate now and then; the next size write restarts decoding
        if ($urandom_range(99) < 10) begin
          cut = int'($urandom_range(code_q.size() - 1));
          while (code_q.size() > cut + 1) void'(code_q.pop_back());
        end
        for (int j = $urandom_range(2); j > 0; j--)
          code_q.push_back($urandom_range(1) ? noise_symbol() : qtd_pkg::SYM_BLACK);
        // hold the sink off so the decoder backs up and drops in_tready
        if (first_tree) hold_req = 1'b1;
        first_tree = 1'b0;
        send_code();
      end
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Sent %0d symbols across %0d size_log writes and four idle/stall mixes",
             sent_total, size_writes);
    $display("Checked %0d leaf results and %0d error results", leaf_count, error_count);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
